@@ hw/rtl/bpd_pkg.sv @@
// Shared types, codes and defaults for the button press duration classifier.
// Depends on nothing; used by bpd_lane, bpd_merge and the top level.
package bpd_pkg;

  // default sizes of the button bank and hold counters
  localparam int unsigned BUTTON_COUNT_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF   = 16;

  // fixed field widths of the stream and configuration ports
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned REG_W    = 2;
  localparam int unsigned OUT_BITS = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 4 * OUT_BITS;

  // register reset values
  localparam logic [LEVEL_W-1:0]  ACTIVE_LEVELS_RST = 8'd0;
  localparam logic [THRESH_W-1:0] SHORT_TICKS_RST   = 16'd10;
  localparam logic [THRESH_W-1:0] LONG_TICKS_RST    = 16'd400;
  localparam logic [THRESH_W-1:0] STUCK_TICKS_RST   = 16'd6000;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 2'd0,
    MODE_CLR_SHORT = 2'd1,
    MODE_CLR_LONG  = 2'd2
  } mode_e;

  typedef enum logic [REG_W-1:0] {
    REG_ACTIVE_LEVELS = 2'd0,
    REG_SHORT_TICKS   = 2'd1,
    REG_LONG_TICKS    = 2'd2,
    REG_STUCK_TICKS   = 2'd3
  } reg_e;

  // per-lane commands for one accepted item
  typedef struct packed {
    logic tick;
    logic clr_short;
    logic clr_long;
  } lane_ctrl_t;

  // per-lane state flags
  typedef struct packed {
    logic pressed;
    logic short_f;
    logic long_f;
    logic stuck_f;
  } lane_flags_t;

  // result item, first field in the highest bits
  typedef struct packed {
    logic [OUT_BITS-1:0] stuck_flags;
    logic [OUT_BITS-1:0] long_flags;
    logic [OUT_BITS-1:0] short_flags;
    logic [OUT_BITS-1:0] pressed_flags;
  } result_t;

endpackage

@@ hw/rtl/bpd_lane.sv @@
// One button lane: pressed state, saturating hold counter and threshold flags.
// Depends on bpd_pkg.
module bpd_lane #(
  parameter int unsigned COUNT_BITS = bpd_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpd_pkg::lane_ctrl_t   ctrl_i,
  input  logic                  raw_i,
  input  logic                  active_i,
  input  logic [COUNT_BITS-1:0] short_th_i,
  input  logic [COUNT_BITS-1:0] long_th_i,
  input  logic [COUNT_BITS-1:0] stuck_th_i,
  output bpd_pkg::lane_flags_t  flags_d_o,
  output bpd_pkg::lane_flags_t  flags_q_o
);

  bpd_pkg::lane_flags_t  flags_d, flags_q;
  logic [COUNT_BITS-1:0] count_d, count_q;
  logic [COUNT_BITS:0]   count_inc;
  logic [COUNT_BITS-1:0] count_sat;
  logic                  is_active;

  // count_q is zero whenever the button is released, so a fresh press starts at one
  assign count_inc = {1'b0, count_q} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign count_sat = (count_inc >= {1'b0, stuck_th_i}) ? stuck_th_i
                                                       : count_inc[COUNT_BITS-1:0];
  assign is_active = (raw_i == active_i);

  always_comb begin
    flags_d = flags_q;
    count_d = count_q;
    if (ctrl_i.tick) begin
      if (is_active != flags_q.pressed) begin
        if (is_active) begin
          flags_d.pressed = 1'b1;
        end else begin
          flags_d = '0;
          count_d = '0;
        end
      end
      if (flags_d.pressed) begin
        count_d = count_sat;
        if (count_sat == short_th_i) flags_d.short_f = 1'b1;
        if (count_sat == long_th_i)  flags_d.long_f  = 1'b1;
        if (count_sat == stuck_th_i) flags_d.stuck_f = 1'b1;
      end
    end else begin
      if (ctrl_i.clr_short) flags_d.short_f = 1'b0;
      if (ctrl_i.clr_long)  flags_d.long_f  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      count_q <= '0;
    end else begin
      flags_q <= flags_d;
      count_q <= count_d;
    end
  end

  assign flags_d_o = flags_d;
  assign flags_q_o = flags_q;

endmodule

@@ hw/rtl/bpd_merge.sv @@
// Merge stage: gathers the lane flags into result vectors and holds the output item.
// Depends on bpd_pkg.
module bpd_merge #(
  parameter int unsigned BUTTON_COUNT = bpd_pkg::BUTTON_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  bpd_pkg::lane_flags_t lanes_i [BUTTON_COUNT],
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output bpd_pkg::result_t     out_data_o,
  output logic                 in_ready_o
);

  bpd_pkg::result_t res_d, res_q;
  logic             valid_q;

  // only the low buttons appear in the result
  for (genvar b = 0; b < bpd_pkg::OUT_BITS; b++) begin : g_bit
    if (b < BUTTON_COUNT) begin : g_lane
      assign res_d.pressed_flags[b] = lanes_i[b].pressed;
      assign res_d.short_flags[b]   = lanes_i[b].short_f;
      assign res_d.long_flags[b]    = lanes_i[b].long_f;
      assign res_d.stuck_flags[b]   = lanes_i[b].stuck_f;
    end else begin : g_none
      assign res_d.pressed_flags[b] = 1'b0;
      assign res_d.short_flags[b]   = 1'b0;
      assign res_d.long_flags[b]    = 1'b0;
      assign res_d.stuck_flags[b]   = 1'b0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

@@ hw/rtl/button_press_duration_classifier.sv @@
// Top level of the button press duration classifier: registers, lanes and merge.
// Depends on bpd_pkg, bpd_lane and bpd_merge.
//
// Use: each slave item is a tick (tuser = tick, tdata carries the raw button
// levels) or a request to clear one button's short or long flag (tdata carries
// the button index). Every accepted item gives exactly one master item with the
// pressed, short, long and stuck vectors as they stand after that item.
// One lane per button updates its pressed bit, hold counter and flags in the
// cycle the item is accepted; the merge stage registers the vectors.
// Latency: the result is valid in the cycle after acceptance.
// Throughput: one item per cycle while the output register is empty or m_axis_tready
// is high; the lane update (increment, saturate and three compares per button) is combinational.
// Stall: the output register holds the result while m_axis_tready is low; a new
// item is still taken in a cycle where the held result is taken.
// Reset: all flags and counters clear, thresholds return to 10, 400 and 6000
// ticks, every button's active level to low. Configuration writes take effect
// at the next item.
module button_press_duration_classifier #(
  parameter int unsigned BUTTON_COUNT = bpd_pkg::BUTTON_COUNT_DEF,
  parameter int unsigned COUNT_BITS   = bpd_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpd_pkg::REG_W-1:0]         cfg_index_i,
  input  logic [bpd_pkg::THRESH_W-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // raw_levels [7:0], button_index [10:8], zero [15:11]
  input  logic [bpd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // mode [1:0]
  input  logic [bpd_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pressed_flags [7:0], short_flags [15:8], long_flags [23:16], stuck_flags [31:24]
  output logic [bpd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  logic [bpd_pkg::LEVEL_W-1:0]  active_q;
  logic [bpd_pkg::THRESH_W-1:0] short_q, long_q, stuck_q;

  logic [bpd_pkg::LEVEL_W-1:0]  s_raw;
  logic [bpd_pkg::INDEX_W-1:0]  s_idx;
  bpd_pkg::mode_e               s_mode;
  logic                         s_acc;
  logic                         is_tick, is_clr_short, is_clr_long;

  logic [COUNT_BITS-1:0] short_th, long_th, stuck_th;

  bpd_pkg::lane_flags_t lane_d [BUTTON_COUNT];
  bpd_pkg::lane_flags_t lane_q [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] pressed_v, short_v, long_v, stuck_v;

  bpd_pkg::result_t res;

  // register file, write only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= bpd_pkg::ACTIVE_LEVELS_RST;
      short_q  <= bpd_pkg::SHORT_TICKS_RST;
      long_q   <= bpd_pkg::LONG_TICKS_RST;
      stuck_q  <= bpd_pkg::STUCK_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (bpd_pkg::reg_e'(cfg_index_i))
        bpd_pkg::REG_ACTIVE_LEVELS: active_q <= cfg_data_i[bpd_pkg::LEVEL_W-1:0];
        bpd_pkg::REG_SHORT_TICKS:   short_q  <= cfg_data_i;
        bpd_pkg::REG_LONG_TICKS:    long_q   <= cfg_data_i;
        bpd_pkg::REG_STUCK_TICKS:   stuck_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // thresholds wrap to the counter width
  assign short_th = COUNT_BITS'(short_q);
  assign long_th  = COUNT_BITS'(long_q);
  assign stuck_th = COUNT_BITS'(stuck_q);

  // unpack the slave item
  assign s_raw  = s_axis_tdata[bpd_pkg::LEVEL_W-1:0];
  assign s_idx  = s_axis_tdata[bpd_pkg::LEVEL_W +: bpd_pkg::INDEX_W];
  assign s_mode = bpd_pkg::mode_e'(s_axis_tuser);
  assign s_acc  = s_axis_tvalid && s_axis_tready;

  // decode the mode; the unused code changes nothing
  always_comb begin
    is_tick      = 1'b0;
    is_clr_short = 1'b0;
    is_clr_long  = 1'b0;
    unique case (s_mode)
      bpd_pkg::MODE_TICK:      is_tick      = s_acc;
      bpd_pkg::MODE_CLR_SHORT: is_clr_short = s_acc;
      bpd_pkg::MODE_CLR_LONG:  is_clr_long  = s_acc;
      default: ;
    endcase
  end

  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
    bpd_pkg::lane_ctrl_t ctrl;
    logic                raw_b, act_b;
    logic                sel;

    // buttons past the level fields see low raw and low active level
    if (b < bpd_pkg::LEVEL_W) begin : g_wired
      assign raw_b = s_raw[b];
      assign act_b = active_q[b];
    end else begin : g_unwired
      assign raw_b = 1'b0;
      assign act_b = 1'b0;
    end

    assign sel            = (32'(s_idx) == b);
    assign ctrl.tick      = is_tick;
    assign ctrl.clr_short = is_clr_short && sel;
    assign ctrl.clr_long  = is_clr_long && sel;

    bpd_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .raw_i      (raw_b),
      .active_i   (act_b),
      .short_th_i (short_th),
      .long_th_i  (long_th),
      .stuck_th_i (stuck_th),
      .flags_d_o  (lane_d[b]),
      .flags_q_o  (lane_q[b])
    );

    assign pressed_v[b] = lane_q[b].pressed;
    assign short_v[b]   = lane_q[b].short_f;
    assign long_v[b]    = lane_q[b].long_f;
    assign stuck_v[b]   = lane_q[b].stuck_f;
  end

  bpd_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s_acc),
    .lanes_i     (lane_d),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (res),
    .in_ready_o  (s_axis_tready)
  );

  assign m_axis_tdata = res;

  // a flag can only be up while its button is pressed
  a_flags_need_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((short_v | long_v | stuck_v) & ~pressed_v) == '0)
    else $error("flag set on a released button");

  // every accepted item leaves a result in the output register
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  // lane state moves only with an accepted item
  a_state_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_acc |=> $stable({pressed_v, short_v, long_v, stuck_v}))
    else $error("lane state changed without an item");

  // a clear request drops the addressed short flag
  a_clear_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_clr_short && (32'(s_idx) < BUTTON_COUNT)) |=> !short_v[$past(s_idx)])
    else $error("short flag survived its clear request");

endmodule
